// ===== hw/rtl/msgpk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msgpk_pkg
// Shared types and constants for the MessagePack value encoder: operation
// codes, type bytes and the classified command that the front hands to the
// serializer.
// ----------------------------------------------------------------------------
package msgpk_pkg;

	typedef logic [2:0] op_t;

	localparam op_t OP_NIL   = 3'd0;
	localparam op_t OP_BOOL  = 3'd1;
	localparam op_t OP_UINT  = 3'd2;
	localparam op_t OP_INT   = 3'd3;
	localparam op_t OP_STR   = 3'd4;
	localparam op_t OP_ARRAY = 3'd5;
	localparam op_t OP_MAP   = 3'd6;
	localparam op_t OP_RAW   = 3'd7;

	localparam logic [7:0] TB_NIL     = 8'hC0;
	localparam logic [7:0] TB_FALSE   = 8'hC2;
	localparam logic [7:0] TB_TRUE    = 8'hC3;
	localparam logic [7:0] TB_UINT8   = 8'hCC;
	localparam logic [7:0] TB_UINT16  = 8'hCD;
	localparam logic [7:0] TB_UINT32  = 8'hCE;
	localparam logic [7:0] TB_UINT64  = 8'hCF;
	localparam logic [7:0] TB_INT8    = 8'hD0;
	localparam logic [7:0] TB_INT16   = 8'hD1;
	localparam logic [7:0] TB_INT32   = 8'hD2;
	localparam logic [7:0] TB_INT64   = 8'hD3;
	localparam logic [7:0] TB_STR8    = 8'hD9;
	localparam logic [7:0] TB_STR16   = 8'hDA;
	localparam logic [7:0] TB_STR32   = 8'hDB;
	localparam logic [7:0] TB_ARRAY16 = 8'hDC;
	localparam logic [7:0] TB_ARRAY32 = 8'hDD;
	localparam logic [7:0] TB_MAP16   = 8'hDE;
	localparam logic [7:0] TB_MAP32   = 8'hDF;
	localparam logic [7:0] TB_FIXSTR  = 8'hA0;
	localparam logic [7:0] TB_FIXARR  = 8'h90;
	localparam logic [7:0] TB_FIXMAP  = 8'h80;
	localparam logic [7:0] TB_NEGFIX  = 8'hE0;

	// number of value bytes after the head byte: 0, 1, 2, 4 or 8
	typedef logic [3:0] nbytes_t;

	typedef struct packed {
		logic [7:0]  head;
		nbytes_t     nbytes;
		logic [63:0] data;    // value bytes, first one in [63:56]
	} cmd_t;

	typedef struct packed {
		logic    mid_run;
		nbytes_t rem;
	} ser_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/msgpk_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msgpk_front
// Classifies one operation and value into a head byte, a value byte count
// and the value bytes left-aligned for the serializer.
// ----------------------------------------------------------------------------
module msgpk_front (
	input  wire msgpk_pkg::op_t operation,
	input  wire logic [63:0]    value,
	output msgpk_pkg::cmd_t     cmd
);

	logic [31:0]        len32;
	logic [7:0]         head;
	msgpk_pkg::nbytes_t nb;

	assign len32 = value[31:0];

	always_comb begin
		head = msgpk_pkg::TB_NIL;
		nb   = 4'd0;
		case (operation)
			msgpk_pkg::OP_NIL: begin
				head = msgpk_pkg::TB_NIL;
			end
			msgpk_pkg::OP_BOOL: begin
				head = (value != 64'd0) ? msgpk_pkg::TB_TRUE : msgpk_pkg::TB_FALSE;
			end
			msgpk_pkg::OP_UINT, msgpk_pkg::OP_INT: begin
				if (!value[63] || operation == msgpk_pkg::OP_UINT) begin
					if (value[63:7] == 57'd0) begin
						head = value[7:0];
					end else if (value[63:8] == 56'd0) begin
						head = msgpk_pkg::TB_UINT8;
						nb   = 4'd1;
					end else if (value[63:16] == 48'd0) begin
						head = msgpk_pkg::TB_UINT16;
						nb   = 4'd2;
					end else if (value[63:32] == 32'd0) begin
						head = msgpk_pkg::TB_UINT32;
						nb   = 4'd4;
					end else begin
						head = msgpk_pkg::TB_UINT64;
						nb   = 4'd8;
					end
				end else begin
					// negative: count the sign-extension run
					if (&value[63:5]) begin
						head = msgpk_pkg::TB_NEGFIX | {3'd0, value[4:0]};
					end else if (&value[63:7]) begin
						head = msgpk_pkg::TB_INT8;
						nb   = 4'd1;
					end else if (&value[63:15]) begin
						head = msgpk_pkg::TB_INT16;
						nb   = 4'd2;
					end else if (&value[63:31]) begin
						head = msgpk_pkg::TB_INT32;
						nb   = 4'd4;
					end else begin
						head = msgpk_pkg::TB_INT64;
						nb   = 4'd8;
					end
				end
			end
			msgpk_pkg::OP_STR: begin
				if (len32[31:5] == 27'd0) begin
					head = msgpk_pkg::TB_FIXSTR | {3'd0, len32[4:0]};
				end else if (len32[31:8] == 24'd0) begin
					head = msgpk_pkg::TB_STR8;
					nb   = 4'd1;
				end else if (len32[31:16] == 16'd0) begin
					head = msgpk_pkg::TB_STR16;
					nb   = 4'd2;
				end else begin
					head = msgpk_pkg::TB_STR32;
					nb   = 4'd4;
				end
			end
			msgpk_pkg::OP_ARRAY, msgpk_pkg::OP_MAP: begin
				if (len32[31:4] == 28'd0) begin
					head = ((operation == msgpk_pkg::OP_ARRAY) ?
						msgpk_pkg::TB_FIXARR : msgpk_pkg::TB_FIXMAP) | {4'd0, len32[3:0]};
				end else if (len32[31:16] == 16'd0) begin
					head = (operation == msgpk_pkg::OP_ARRAY) ?
						msgpk_pkg::TB_ARRAY16 : msgpk_pkg::TB_MAP16;
					nb   = 4'd2;
				end else begin
					head = (operation == msgpk_pkg::OP_ARRAY) ?
						msgpk_pkg::TB_ARRAY32 : msgpk_pkg::TB_MAP32;
					nb   = 4'd4;
				end
			end
			default: begin
				head = value[7:0];
			end
		endcase
	end

	always_comb begin
		cmd.head   = head;
		cmd.nbytes = nb;
		case (nb)
			4'd1:    cmd.data = {value[7:0], 56'd0};
			4'd2:    cmd.data = {value[15:0], 48'd0};
			4'd4:    cmd.data = {value[31:0], 32'd0};
			default: cmd.data = value;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/msgpk_cmdq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msgpk_cmdq
// Short queue of classified commands between the front and the serializer.
// ----------------------------------------------------------------------------
module msgpk_cmdq #(
	parameter int DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire msgpk_pkg::cmd_t wr_cmd,
	output logic                 q_full,
	input  wire logic            rd_en,
	output msgpk_pkg::cmd_t      rd_cmd,
	output logic                 q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	msgpk_pkg::cmd_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign q_full  = (cnt_q == CNT_W'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/msgpk_ser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msgpk_ser
// Serializer: turns each command into its head byte and value bytes, one
// byte per cycle into an output register while the consumer keeps popping.
// ----------------------------------------------------------------------------
module msgpk_ser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire msgpk_pkg::cmd_t q_cmd,
	input  wire logic            q_empty,
	output logic                 q_pop,
	output logic                 empty,
	input  wire logic            pop,
	output logic [7:0]           out_byte,
	output logic                 last,
	output msgpk_pkg::ser_stat_t stat
);

	logic               ovalid_q;
	msgpk_pkg::nbytes_t rem_q;
	logic [63:0]        data_q;
	logic [7:0]         byte_q;
	logic               last_q;
	logic               adv;

	// output register free or being drained this cycle
	assign adv   = !ovalid_q || pop;
	assign q_pop = adv && (rem_q == '0) && !q_empty;

	assign empty    = !ovalid_q;
	assign out_byte = byte_q;
	assign last     = last_q;

	assign stat.mid_run = (rem_q != '0);
	assign stat.rem     = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			rem_q    <= '0;
		end else if (adv) begin
			if (rem_q != '0) begin
				ovalid_q <= 1'b1;
				rem_q    <= rem_q - 1'b1;
			end else if (!q_empty) begin
				ovalid_q <= 1'b1;
				rem_q    <= q_cmd.nbytes;
			end else begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (rem_q != '0) begin
				byte_q <= data_q[63:56];
				last_q <= (rem_q == 4'd1);
				data_q <= {data_q[55:0], 8'd0};
			end else if (!q_empty) begin
				byte_q <= q_cmd.head;
				last_q <= (q_cmd.nbytes == '0);
				data_q <= q_cmd.data;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/msgpack_value_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msgpack_value_encoder
// Encodes nil, bool, integer, header and raw byte values into MessagePack
// bytes, shortest form first, last byte of each run flagged.
// ----------------------------------------------------------------------------
//  channel | handshake        | payload
//  input   | push / full      | operation[2:0], value[63:0]
//  result  | pop / empty      | out_byte[7:0], last
//
// one byte leaves per cycle while pop drains the output; an item is 1 to 9 encoded bytes
// the serializer's single output byte register sets that rate
// the front classifies in the accept cycle and the queue parks up to QUEUE_DEPTH items
// reset clears the queue pointers and the output register valid
// a stalled pop holds the current byte; full rises once the queue fills
// ----------------------------------------------------------------------------
module msgpack_value_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  operation,
	input  wire logic [63:0] value,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             last
);

	msgpk_pkg::cmd_t      front_cmd;
	msgpk_pkg::cmd_t      q_cmd;
	msgpk_pkg::ser_stat_t ser_stat;
	logic                 q_empty;
	logic                 q_pop;

	msgpk_front u_front (
		.operation (operation),
		.value     (value),
		.cmd       (front_cmd)
	);

	msgpk_cmdq #(
		.DEPTH (QUEUE_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !full),
		.wr_cmd  (front_cmd),
		.q_full  (full),
		.rd_en   (q_pop),
		.rd_cmd  (q_cmd),
		.q_empty (q_empty)
	);

	msgpk_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_cmd    (q_cmd),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.last     (last),
		.stat     (ser_stat)
	);

	// a run in progress always has a byte on the result ports
	a_run_visible: assert property (@(posedge clk) disable iff (!arst_n)
		ser_stat.mid_run |-> !empty)
		else $error("run in progress with no byte presented");

	// a non-final byte is followed by the next byte of its run at once
	a_run_streams: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=> !empty)
		else $error("gap inside an encoded run");

	// never more value bytes pending than the widest form
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ser_stat.rem <= 4'd8)
		else $error("pending byte count out of range");

endmodule
`default_nettype wire

// ===== dv/tb_msgpack_value_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msgpack_value_encoder
// Pushes directed corner values and random items, including string headers
// followed by their content bytes and containers followed by their elements,
// through the encoder. Every popped byte and last flag is checked against a
// local encoder model. Both handshakes idle at random, and the result side
// holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_msgpack_value_encoder;

	typedef struct {
		msgpk_pkg::op_t op;
		logic [63:0]    operand;
	} enc_item_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} enc_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [2:0]  operation = msgpk_pkg::OP_NIL;
	logic [63:0] value = '0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  out_byte;
	logic        last;

	enc_item_t   pending_items[$];
	enc_byte_t   expected_bytes[$];
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	logic        rx_stall_start = 1'b0;
	int unsigned rx_stall_left = 0;
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned bytes_checked = 0;

	msgpack_value_encoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.operation(operation),
		.value    (value),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.last     (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// shortest encoding of one item, appended to the expected byte stream
	function automatic void predict_encoding(msgpk_pkg::op_t op, logic [63:0] v);
		logic [7:0]  head;
		int          nbytes;
		logic [31:0] len;
		enc_byte_t   b;
		len = v[31:0];
		head = '0;
		nbytes = 0;
		case (op)
		msgpk_pkg::OP_NIL: head = msgpk_pkg::TB_NIL;
		msgpk_pkg::OP_BOOL: head = (v != '0) ? msgpk_pkg::TB_TRUE : msgpk_pkg::TB_FALSE;
		msgpk_pkg::OP_UINT, msgpk_pkg::OP_INT: begin
			if (op == msgpk_pkg::OP_INT && v[63]) begin
				if (v >= 64'hFFFF_FFFF_FFFF_FFE0) begin
					head = msgpk_pkg::TB_NEGFIX | {3'b000, v[4:0]};
				end else if (v >= 64'hFFFF_FFFF_FFFF_FF80) begin
					head = msgpk_pkg::TB_INT8;
					nbytes = 1;
				end else if (v >= 64'hFFFF_FFFF_FFFF_8000) begin
					head = msgpk_pkg::TB_INT16;
					nbytes = 2;
				end else if (v >= 64'hFFFF_FFFF_8000_0000) begin
					head = msgpk_pkg::TB_INT32;
					nbytes = 4;
				end else begin
					head = msgpk_pkg::TB_INT64;
					nbytes = 8;
				end
			end else if (v <= 64'h7F) begin
				head = v[7:0];
			end else if (v <= 64'hFF) begin
				head = msgpk_pkg::TB_UINT8;
				nbytes = 1;
			end else if (v <= 64'hFFFF) begin
				head = msgpk_pkg::TB_UINT16;
				nbytes = 2;
			end else if (v <= 64'hFFFF_FFFF) begin
				head = msgpk_pkg::TB_UINT32;
				nbytes = 4;
			end else begin
				head = msgpk_pkg::TB_UINT64;
				nbytes = 8;
			end
		end
		msgpk_pkg::OP_STR: begin
			if (len < 32'h20) begin
				head = msgpk_pkg::TB_FIXSTR | len[7:0];
			end else if (len < 32'h100) begin
				head = msgpk_pkg::TB_STR8;
				nbytes = 1;
			end else if (len < 32'h1_0000) begin
				head = msgpk_pkg::TB_STR16;
				nbytes = 2;
			end else begin
				head = msgpk_pkg::TB_STR32;
				nbytes = 4;
			end
		end
		msgpk_pkg::OP_ARRAY, msgpk_pkg::OP_MAP: begin
			if (len < 32'h10) begin
				head = ((op == msgpk_pkg::OP_ARRAY) ? msgpk_pkg::TB_FIXARR :
					msgpk_pkg::TB_FIXMAP) | len[7:0];
			end else if (len < 32'h1_0000) begin
				head = (op == msgpk_pkg::OP_ARRAY) ? msgpk_pkg::TB_ARRAY16 :
					msgpk_pkg::TB_MAP16;
				nbytes = 2;
			end else begin
				head = (op == msgpk_pkg::OP_ARRAY) ? msgpk_pkg::TB_ARRAY32 :
					msgpk_pkg::TB_MAP32;
				nbytes = 4;
			end
		end
		default: head = v[7:0];
		endcase
		b.data = head;
		b.last = (nbytes == 0);
		expected_bytes.push_back(b);
		// value bytes go out big-endian, low bytes of the operand only
		for (int i = nbytes - 1; i >= 0; i--) begin
			b.data = v[8 * i +: 8];
			b.last = (i == 0);
			expected_bytes.push_back(b);
		end
	endfunction

	// magnitude spread evenly over bit widths so every size class shows up
	function automatic logic [63:0] random_operand(msgpk_pkg::op_t op);
		logic [63:0] r;
		int unsigned w;
		r = {$urandom, $urandom};
		w = $urandom_range(64, 1);
		if (w < 64) begin
			r = r & ((64'd1 << w) - 64'd1);
		end
		if (op == msgpk_pkg::OP_INT && $urandom_range(1) == 1) begin
			r = ~r;
		end
		if (op == msgpk_pkg::OP_BOOL && $urandom_range(3) == 0) begin
			r = '0;
		end
		return r;
	endfunction

	task automatic queue_item(input msgpk_pkg::op_t op, input logic [63:0] operand);
		enc_item_t it;
		it.op = op;
		it.operand = operand;
		pending_items.push_back(it);
	endtask

	task automatic fill_random(input int unsigned target);
		int unsigned    added;
		int unsigned    len;
		int unsigned    kind;
		msgpk_pkg::op_t op;
		added = 0;
		while (added < target) begin
			kind = $urandom_range(9);
			if (kind < 3) begin
				// string header followed by its content, junk in the upper bits
				len = $urandom_range(12);
				queue_item(msgpk_pkg::OP_STR, {$urandom, 32'(len)});
				for (int i = 0; i < len; i++) begin
					queue_item(msgpk_pkg::OP_RAW, {$urandom, $urandom});
				end
				added += len + 1;
			end else if (kind < 5) begin
				op = ($urandom_range(1) == 1) ? msgpk_pkg::OP_ARRAY : msgpk_pkg::OP_MAP;
				len = $urandom_range(5);
				queue_item(op, 64'(len));
				if (op == msgpk_pkg::OP_MAP) begin
					len = 2 * len;
				end
				for (int i = 0; i < len; i++) begin
					op = msgpk_pkg::op_t'($urandom_range(3));
					queue_item(op, random_operand(op));
				end
				added += len + 1;
			end else begin
				op = msgpk_pkg::op_t'($urandom_range(7));
				queue_item(op, random_operand(op));
				added++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_bytes.size() != 0 || push) begin
			@(negedge clk);
		end
	endtask

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: mismatch: %s", $realtime, what);
		end
	endtask

	// driver: holds an offered item until the transaction completes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			operation <= msgpk_pkg::OP_NIL;
			value <= '0;
		end else begin
			if (push && !full) begin
				predict_encoding(operation, value);
				items_sent++;
				pending_items.delete(0);
			end
			if (!push || !full) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					push <= 1'b1;
					operation <= pending_items[0].op;
					value <= pending_items[0].operand;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here once requested
	always @(posedge clk) begin
		if (rx_stall_start) begin
			rx_stall_left <= 300;
		end else if (rx_stall_left != 0) begin
			rx_stall_left <= rx_stall_left - 1;
		end
	end

	// monitor: checks each popped byte against the oldest expected one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				bytes_checked++;
				if (expected_bytes.size() == 0) begin
					flag_mismatch($sformatf("unexpected byte %02h last %0d", out_byte, last));
				end else begin
					if (out_byte !== expected_bytes[0].data || last !== expected_bytes[0].last) begin
						flag_mismatch($sformatf("out_byte exp %02h got %02h, last exp %0d got %0d",
							expected_bytes[0].data, out_byte, expected_bytes[0].last, last));
					end
					expected_bytes.delete(0);
				end
			end
			pop <= (rx_stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 26;
		rx_idle_pct = 56;
		// long result stall while items keep coming, so full must rise
		rx_stall_start = 1'b1;
		queue_item(msgpk_pkg::OP_NIL, '1);
		queue_item(msgpk_pkg::OP_BOOL, 64'h0);
		queue_item(msgpk_pkg::OP_BOOL, 64'h8000_0000_0000_0000);
		queue_item(msgpk_pkg::OP_UINT, 64'h7F);
		queue_item(msgpk_pkg::OP_UINT, 64'h80);
		queue_item(msgpk_pkg::OP_UINT, 64'h100);
		queue_item(msgpk_pkg::OP_UINT, 64'h1_0000);
		queue_item(msgpk_pkg::OP_UINT, '1);
		queue_item(msgpk_pkg::OP_INT, 64'h7FFF_FFFF_FFFF_FFFF);
		queue_item(msgpk_pkg::OP_INT, -64'sd32);
		queue_item(msgpk_pkg::OP_INT, -64'sd33);
		queue_item(msgpk_pkg::OP_INT, -64'sd129);
		queue_item(msgpk_pkg::OP_INT, -64'sd32769);
		queue_item(msgpk_pkg::OP_INT, 64'h8000_0000_0000_0000);
		queue_item(msgpk_pkg::OP_STR, 64'd31);
		queue_item(msgpk_pkg::OP_STR, 64'd32);
		queue_item(msgpk_pkg::OP_STR, 64'h100);
		queue_item(msgpk_pkg::OP_STR, 64'hFFFF_FFFF_0001_0000);
		queue_item(msgpk_pkg::OP_ARRAY, 64'd15);
		queue_item(msgpk_pkg::OP_ARRAY, 64'd16);
		queue_item(msgpk_pkg::OP_ARRAY, 64'h0000_0000_FFFF_FFFF);
		queue_item(msgpk_pkg::OP_MAP, 64'd0);
		queue_item(msgpk_pkg::OP_MAP, 64'hFFFF_0000_0000_FFFF);
		queue_item(msgpk_pkg::OP_MAP, 64'h1_0000);
		queue_item(msgpk_pkg::OP_RAW, 64'hFFFF_FFFF_FFFF_FF00);
		queue_item(msgpk_pkg::OP_RAW, 64'h0000_0000_0000_00A5);
		fill_random(150);
		@(negedge clk);
		rx_stall_start = 1'b0;
		wait_drained();

		tx_idle_pct = 56;
		rx_idle_pct = 26;
		fill_random(150);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		fill_random(150);
		wait_drained();

		repeat (20) @(negedge clk);
		$display("covered %0d items over all operations and size classes, %0d bytes checked",
			items_sent, bytes_checked);
		$display("pacing: sender-heavy idle, receiver-heavy idle, none, plus a long result stall");
		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d bytes still expected", mismatches, expected_bytes.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d bytes still expected", expected_bytes.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
